// ===== rtl/mbsh_pkg.sv =====
// Package for the mu-law bitcrusher: widths, sequencer states, the multiply-accumulate
// request type and the companding curve tables, built at elaboration.
// Depends on nothing; every module of the block imports it.
package mbsh_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int FBITS       = SAMPLE_W - 1;
  localparam int CURVE_DEPTH = 1024;
  localparam int LOG_DEPTH   = $clog2(CURVE_DEPTH);
  localparam int CURVE_AW    = $clog2(CURVE_DEPTH + 1);

  localparam int MAC_AW   = SAMPLE_W + 2;
  localparam int MAC_BW   = SAMPLE_W;
  localparam int ACC_W    = MAC_AW + MAC_BW + 2;
  localparam int DIV_NW   = SAMPLE_W + 1;
  localparam int DIV_DW   = SAMPLE_W - 1;

  localparam logic [63:0] Q30_ONE      = 64'h0000_0000_4000_0000;
  localparam logic [63:0] INV_LOG2_255 = 64'd537250114;

  // Configuration register indexes.
  localparam logic [1:0] REG_HOLD_RATE  = 2'd0;
  localparam logic [1:0] REG_QUANT_STEP = 2'd1;
  localparam logic [1:0] REG_WET_MIX    = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_C_RD0,
    S_C_RD1,
    S_C_MUL,
    S_C_RES,
    S_DIV,
    S_QMUL,
    S_QSCL,
    S_QCLP,
    S_E_RD0,
    S_E_RD1,
    S_E_MUL,
    S_E_RES,
    S_HOLD0,
    S_HOLD1,
    S_HOLD2,
    S_HOLD3,
    S_HOLD4,
    S_SLEW0,
    S_SLEW1,
    S_SLEW2,
    S_SLEW3,
    S_MIX,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                     en;
    logic                     clr;
    logic signed [MAC_AW-1:0] a;
    logic signed [MAC_BW-1:0] b;
  } mac_op_t;

  typedef logic [SAMPLE_W-1:0] curve_tab_t [0:CURVE_DEPTH];

  // Truncating log2 of a Q.30 value of at least one, result in Q.30.
  function automatic logic [63:0] log2_q30(logic [63:0] y_in);
    logic [63:0] y;
    logic [63:0] r;
    y = y_in;
    r = '0;
    if (y < Q30_ONE) begin
      return '0;
    end
    while (y >= (Q30_ONE << 1)) begin
      y = y >> 1;
      r = r + Q30_ONE;
    end
    for (int b = 29; b >= 0; b--) begin
      y = (y * y) >> 30;
      if (y >= (Q30_ONE << 1)) begin
        y = y >> 1;
        r = r | (64'd1 << b);
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] expander_log(logic [63:0] v);
    logic [63:0] u;
    u = 64'd255 * v;
    return log2_q30(Q30_ONE + ((u << 24) >> (FBITS - 6)));
  endfunction

  function automatic curve_tab_t build_comp_tab();
    curve_tab_t  tab;
    logic [63:0] y;
    logic [63:0] l;
    logic [63:0] prod;
    for (int i = 0; i <= CURVE_DEPTH; i++) begin
      y      = Q30_ONE + (((64'd255 * 64'(i)) << 30) / CURVE_DEPTH);
      l      = log2_q30(y);
      prod   = (l * INV_LOG2_255) >> (62 - FBITS);
      tab[i] = prod[SAMPLE_W-1:0];
    end
    return tab;
  endfunction

  function automatic curve_tab_t build_exp_tab();
    curve_tab_t  tab;
    logic [63:0] t;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    for (int i = 0; i <= CURVE_DEPTH; i++) begin
      t  = ((64'd8 * 64'(i)) << 30) / CURVE_DEPTH;
      lo = '0;
      hi = 64'd1 << FBITS;
      while (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (expander_log(mid) <= t) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
      tab[i] = lo[SAMPLE_W-1:0];
    end
    return tab;
  endfunction

endpackage

// ===== rtl/mulaw_bitcrush_sample_hold.sv =====
// Top level of the mu-law bitcrusher with sample-and-hold rate reduction.
// Depends on mbsh_pkg, mbsh_curve_rom, mbsh_div and mbsh_mac.
//
// Usage: one request on the input channel carries one Q1.23 sample. The block
// is busy with it and holds sample_in_stall high until the processed sample
// has been loaded into the output register, so one sample is in work at a time.
// An item runs from acceptance to sample_out_valid through the sequencer:
// the 25-step divider of the quantizer takes most of that time, and the
// shared multiply-accumulate unit takes one product a cycle for the rest;
// the hold-stage interpolation adds S_HOLD1 to S_HOLD4 where the phase wraps.
// The output register keeps its request while sample_out_stall is high; the
// next sample may be accepted and processed meanwhile, and its last step
// waits until the output register is free.
// Configuration writes (wr_en, wr_index, wr_data) are taken in any cycle and
// should be made while the block is idle; an index beyond the last is ignored.
// Synchronous reset restores the default rate, step and mix, and clears the
// hold phase, held values and the output valid flag. No clearing pass is needed.
module mulaw_bitcrush_sample_hold
  import mbsh_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_in_valid,
  output logic                       sample_in_stall,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       sample_out_valid,
  input  logic                       sample_out_stall,
  output logic signed [SAMPLE_W-1:0] sample_out,
  input  logic                       wr_en,
  input  logic [1:0]                 wr_index,
  input  logic [16:0]                wr_data
);

  localparam logic [16:0] UNITY = 17'd65536;
  localparam logic signed [35:0] SAT_MAX = 36'sd8388607;
  localparam logic signed [35:0] SAT_MIN = -36'sd8388608;

  state_t state, state_next;

  logic [15:0] hold_rate;
  logic [15:0] quant_step;
  logic [16:0] wet_mix;

  logic signed [SAMPLE_W-1:0] prev_dry;
  logic signed [SAMPLE_W-1:0] held_value;
  logic signed [SAMPLE_W-1:0] prev_unsoftened;
  logic [16:0]                hold_phase;

  logic signed [SAMPLE_W-1:0] x;
  logic [SAMPLE_W-1:0]        mag;
  logic [SAMPLE_W-1:0]        t0;
  logic [SAMPLE_W-1:0]        qv;
  logic signed [SAMPLE_W-1:0] w;
  logic [16:0]                p;
  logic signed [SAMPLE_W-1:0] nh;
  logic signed [SAMPLE_W-1:0] held_out;
  logic [16:0]                slew;

  mac_op_t                 mac_op;
  logic signed [ACC_W-1:0] acc;
  logic                    rom_sel;
  logic [CURVE_AW-1:0]     rom_addr;
  logic [SAMPLE_W-1:0]     rom_data;
  logic                    div_start;
  logic [DIV_NW-1:0]       div_dividend;
  logic [DIV_NW-1:0]       quot;
  logic                    div_done;

  logic [16:0]             step;
  logic [DIV_DW-1:0]       rez;
  logic [16:0]             gain;
  logic [SAMPLE_W-1:0]     curve_in;
  logic [CURVE_AW-1:0]     idx;
  logic [CURVE_AW-1:0]     idx1;
  logic [SAMPLE_W-1:0]     fr;
  logic signed [ACC_W-1:0] acc_sh23;
  logic signed [ACC_W-1:0] acc_sh16;
  logic signed [25:0]      interp;
  logic [24:0]             interp_pos;
  logic [SAMPLE_W-1:0]     w_val;
  logic [17:0]             ph;
  logic                    ph_wrap;
  logic signed [24:0]      d_signed;
  logic [24:0]             d_abs;
  logic [16:0]             slew_val;
  logic signed [SAMPLE_W-1:0] acc_mix;
  logic [SAMPLE_W-1:0]     q_clamped;
  logic                    out_free;

  mbsh_curve_rom u_rom (
    .clk     (clk),
    .sel_exp (rom_sel),
    .addr    (rom_addr),
    .rd_data (rom_data)
  );

  mbsh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (rez),
    .quotient (quot),
    .done     (div_done)
  );

  mbsh_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .acc (acc)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_rate  <= 16'd32768;
      quant_step <= 16'd32768;
      wet_mix    <= UNITY;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_HOLD_RATE:  hold_rate  <= wr_data[15:0];
        REG_QUANT_STEP: quant_step <= wr_data[15:0];
        REG_WET_MIX:    wet_mix    <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (quant_step < 16'd16) begin
      step = 17'd16;
    end else if (quant_step > 16'd32768) begin
      step = 17'd32768;
    end else begin
      step = {1'b0, quant_step};
    end
    rez  = {step[15:0], 7'd0};
    gain = (wet_mix > UNITY) ? UNITY : wet_mix;

    // Curve lookup: the top bits index the table, the rest interpolate.
    curve_in = rom_sel ? qv : mag;
    idx      = curve_in[FBITS -: CURVE_AW];
    idx1     = (idx == CURVE_AW'(CURVE_DEPTH)) ? idx : idx + CURVE_AW'(1);
    fr       = {1'b0, curve_in[FBITS-LOG_DEPTH-1:0], LOG_DEPTH'(0)};

    acc_sh23   = acc >>> FBITS;
    acc_sh16   = acc >>> 16;
    interp     = $signed({2'b00, t0}) + acc_sh23[25:0];
    interp_pos = interp[25] ? 25'd0 : interp[24:0];
    div_dividend = interp_pos + {2'b00, rez} - 25'd1;

    if (acc_sh16 > 36'sd8388608) begin
      q_clamped = 24'd8388608;
    end else begin
      q_clamped = acc_sh16[SAMPLE_W-1:0];
    end

    // Expanded magnitude with the sign put back; +1.0 saturates.
    if (x == '0) begin
      w_val = '0;
    end else if (x[SAMPLE_W-1]) begin
      w_val = 24'(-interp_pos);
    end else if (interp_pos >= 25'd8388608) begin
      w_val = 24'd8388607;
    end else begin
      w_val = interp_pos[SAMPLE_W-1:0];
    end

    ph      = {1'b0, hold_phase} + {2'b00, hold_rate};
    ph_wrap = ph > 18'd65536;

    d_signed = 25'(held_out) - 25'(prev_unsoftened);
    d_abs    = d_signed[24] ? 25'(-d_signed) : d_signed;
    slew_val = (acc_sh23 > 52'sd32768) ? 17'd32768 : acc_sh23[16:0];

    if (acc_sh16 > SAT_MAX) begin
      acc_mix = 24'sd8388607;
    end else if (acc_sh16 < SAT_MIN) begin
      acc_mix = -24'sd8388608;
    end else begin
      acc_mix = acc_sh16[SAMPLE_W-1:0];
    end

    out_free = !sample_out_valid || !sample_out_stall;
  end

  assign sample_in_stall = (state != S_IDLE);

  // Sequencer: next state and the requests to the shared units.
  always_comb begin
    state_next = state;
    mac_op     = '{en: 1'b0, clr: 1'b0, a: '0, b: '0};
    rom_sel    = 1'b0;
    rom_addr   = idx;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (sample_in_valid) begin
          state_next = S_C_RD0;
        end
      end
      S_C_RD0: begin
        state_next = S_C_RD1;
      end
      S_C_RD1: begin
        rom_addr   = idx1;
        state_next = S_C_MUL;
      end
      S_C_MUL: begin
        mac_op = '{en: 1'b1, clr: 1'b1,
                   a: $signed({2'b00, rom_data}) - $signed({2'b00, t0}),
                   b: $signed(fr)};
        state_next = S_C_RES;
      end
      S_C_RES: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_QMUL;
        end
      end
      S_QMUL: begin
        mac_op = '{en: 1'b1, clr: 1'b1, a: $signed({1'b0, quot}),
                   b: $signed({1'b0, rez})};
        state_next = S_QSCL;
      end
      S_QSCL: begin
        mac_op = '{en: 1'b1, clr: 1'b1, a: acc[MAC_AW-1:0],
                   b: $signed({7'd0, UNITY - step})};
        state_next = S_QCLP;
      end
      S_QCLP: begin
        state_next = S_E_RD0;
      end
      S_E_RD0: begin
        rom_sel    = 1'b1;
        state_next = S_E_RD1;
      end
      S_E_RD1: begin
        rom_sel    = 1'b1;
        rom_addr   = idx1;
        state_next = S_E_MUL;
      end
      S_E_MUL: begin
        rom_sel = 1'b1;
        mac_op = '{en: 1'b1, clr: 1'b1,
                   a: $signed({2'b00, rom_data}) - $signed({2'b00, t0}),
                   b: $signed(fr)};
        state_next = S_E_RES;
      end
      S_E_RES: begin
        rom_sel    = 1'b1;
        state_next = S_HOLD0;
      end
      S_HOLD0: begin
        if (ph_wrap) begin
          mac_op = '{en: 1'b1, clr: 1'b1, a: MAC_AW'(prev_dry),
                     b: $signed({7'd0, ph[16:0] ^ 17'h10000})};
          state_next = S_HOLD1;
        end else begin
          state_next = S_SLEW0;
        end
      end
      S_HOLD1: begin
        mac_op = '{en: 1'b1, clr: 1'b0, a: MAC_AW'(w),
                   b: $signed({7'd0, UNITY - p})};
        state_next = S_HOLD2;
      end
      S_HOLD2: begin
        mac_op = '{en: 1'b1, clr: 1'b1, a: MAC_AW'(acc_mix),
                   b: $signed({7'd0, UNITY - p})};
        state_next = S_HOLD3;
      end
      S_HOLD3: begin
        mac_op = '{en: 1'b1, clr: 1'b0, a: MAC_AW'(held_value),
                   b: $signed({7'd0, p})};
        state_next = S_HOLD4;
      end
      S_HOLD4: begin
        state_next = S_SLEW0;
      end
      S_SLEW0: begin
        mac_op = '{en: 1'b1, clr: 1'b1, a: $signed({1'b0, d_abs}),
                   b: $signed({8'd0, hold_rate})};
        state_next = S_SLEW1;
      end
      S_SLEW1: begin
        mac_op = '{en: 1'b1, clr: 1'b1, a: MAC_AW'(held_out),
                   b: $signed({7'd0, slew_val})};
        state_next = S_SLEW2;
      end
      S_SLEW2: begin
        mac_op = '{en: 1'b1, clr: 1'b0, a: MAC_AW'(prev_unsoftened),
                   b: $signed({7'd0, UNITY - slew})};
        state_next = S_SLEW3;
      end
      S_SLEW3: begin
        mac_op = '{en: 1'b1, clr: 1'b1, a: MAC_AW'(acc_mix),
                   b: $signed({7'd0, gain})};
        state_next = S_MIX;
      end
      S_MIX: begin
        mac_op = '{en: 1'b1, clr: 1'b0, a: MAC_AW'(x),
                   b: $signed({7'd0, UNITY - gain})};
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Persistent state of the hold and softening stages, and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_dry         <= '0;
      held_value       <= '0;
      prev_unsoftened  <= '0;
      hold_phase       <= '0;
      sample_out_valid <= 1'b0;
    end else begin
      if (sample_out_valid && !sample_out_stall) begin
        sample_out_valid <= 1'b0;
      end
      unique case (state)
        S_HOLD0: begin
          hold_phase <= ph_wrap ? (ph[16:0] ^ 17'h10000) : ph[16:0];
        end
        S_HOLD4: begin
          held_value <= nh;
        end
        S_SLEW3: begin
          prev_dry        <= x;
          prev_unsoftened <= held_out;
        end
        S_OUT: begin
          if (out_free) begin
            sample_out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the item in progress.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        x   <= sample_in;
        mag <= sample_in[SAMPLE_W-1] ? SAMPLE_W'(-sample_in) : sample_in;
      end
      S_C_RD1, S_E_RD1: begin
        t0 <= rom_data;
      end
      S_QCLP: begin
        qv <= q_clamped;
      end
      S_E_RES: begin
        w <= w_val;
      end
      S_HOLD0: begin
        held_out <= held_value;
        p        <= ph[16:0] ^ 17'h10000;
      end
      S_HOLD2: begin
        nh <= acc_mix;
      end
      S_HOLD4: begin
        held_out <= acc_mix;
      end
      S_SLEW1: begin
        slew <= slew_val;
      end
      S_OUT: begin
        if (out_free) begin
          sample_out <= acc_mix;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/mbsh_curve_rom.sv =====
// Read-only store of the compressor and expander curves, one registered read port.
// Depends on mbsh_pkg for the table builders and widths.
module mbsh_curve_rom
  import mbsh_pkg::*;
(
  input  logic                clk,
  input  logic                sel_exp,
  input  logic [CURVE_AW-1:0] addr,
  output logic [SAMPLE_W-1:0] rd_data
);

  localparam curve_tab_t COMP_TAB = build_comp_tab();
  localparam curve_tab_t EXP_TAB  = build_exp_tab();

  always_ff @(posedge clk) begin
    if (sel_exp) begin
      rd_data <= EXP_TAB[addr];
    end else begin
      rd_data <= COMP_TAB[addr];
    end
  end

endmodule

// ===== rtl/mbsh_div.sv =====
// Restoring divider, one quotient bit per cycle, for the quantizer's step count.
// Depends on mbsh_pkg for its operand widths.
module mbsh_div
  import mbsh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic [DIV_NW-1:0] quotient,
  output logic              done
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   trial;
  logic              fits;

  always_comb begin
    shifted = {rem, quotient[DIV_NW-1]};
    trial   = shifted - {1'b0, dsr};
    fits    = shifted >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= trial[DIV_DW-1:0];
      end else begin
        rem <= shifted[DIV_DW-1:0];
      end
      quotient <= {quotient[DIV_NW-2:0], fits};
    end
  end

endmodule

// ===== rtl/mbsh_mac.sv =====
// Shared signed multiply-accumulate unit; every product of the datapath goes through it.
// Depends on mbsh_pkg for the request type and accumulator width.
module mbsh_mac
  import mbsh_pkg::*;
(
  input  logic                    clk,
  input  mac_op_t                 op,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [ACC_W-1:0] prod;

  assign prod = ACC_W'(op.a * op.b);

  always_ff @(posedge clk) begin
    if (op.en) begin
      if (op.clr) begin
        acc <= prod;
      end else begin
        acc <= acc + prod;
      end
    end
  end

endmodule
